FILE: sv/sctl_pkg.sv
package sctl_pkg;

  localparam int TEXT_BYTES        = 8;
  localparam int TEXT_W            = 8 * TEXT_BYTES;
  localparam int LANE_BITS         = $clog2(TEXT_BYTES);
  localparam int POSITION_BITS_DEF = 16;
  localparam int OUT_POS_W         = 16;
  localparam int LEN_W             = 8;
  localparam int FIXED_N           = 10;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CNT_W             = $clog2(QUEUE_DEPTH + 1);

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_INTRINSIC = 4'd0;
  localparam kind_t KIND_KEYWORD   = 4'd1;
  localparam kind_t KIND_IDENT     = 4'd2;
  localparam kind_t KIND_CONST     = 4'd3;
  localparam kind_t KIND_EQUALS    = 4'd4;
  localparam kind_t KIND_TYPE      = 4'd5;
  localparam kind_t KIND_ARROW     = 4'd6;
  localparam kind_t KIND_COLON     = 4'd7;
  localparam kind_t KIND_OPEN      = 4'd8;
  localparam kind_t KIND_CLOSE     = 4'd9;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;

  // fixed words, first byte in the lowest byte, checked in list order
  localparam logic [TEXT_W-1:0] FIXED_TEXT [FIXED_N] = '{
    64'h4C4C_4143_5F53_5953,  // intrinsic word
    64'h0000_0000_0000_3E2D,  // ->
    64'h0000_0000_0032_3369,  // i32
    64'h0000_0000_6469_6F76,  // void
    64'h0000_676E_6972_7473,  // string
    64'h0000_0000_636E_7566,  // func
    64'h0065_6475_6C63_6E69,  // include
    64'h0000_0000_0000_6F64,  // do
    64'h0000_0000_0064_6E65,  // end
    64'h0000_0000_646E_6962   // bind
  };

  localparam logic [LEN_W-1:0] FIXED_LEN [FIXED_N] = '{
    8'd8, 8'd2, 8'd3, 8'd4, 8'd6, 8'd4, 8'd7, 8'd2, 8'd3, 8'd4
  };

  localparam kind_t FIXED_KIND [FIXED_N] = '{
    KIND_INTRINSIC, KIND_ARROW, KIND_TYPE, KIND_TYPE, KIND_TYPE,
    KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD
  };

  typedef struct packed {
    kind_t                kind;
    logic [TEXT_W-1:0]    text;
    logic [LEN_W-1:0]     length;
    logic                 trunc;
    logic [OUT_POS_W-1:0] line;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } push_t;

endpackage

FILE: sv/sctl_lexer.sv
module sctl_lexer
  import sctl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  output push_t      push
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [TEXT_W-1:0]        word_text_r, word_text_nxt;
  logic [LEN_W-1:0]         word_len_r, word_len_nxt;
  logic                     letters_r, letters_nxt;
  logic [POSITION_BITS-1:0] row_r, row_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;

  logic  is_delim;
  logic  is_letter;
  kind_t word_kind;
  kind_t own_kind;
  logic [POSITION_BITS-1:0] col_bump;

  always_comb begin
    word_kind = letters_r ? KIND_IDENT : KIND_CONST;
    if (word_text_r[7:0] == CH_EQ) word_kind = KIND_EQUALS;
    for (int i = FIXED_N - 1; i >= 0; i--) begin
      if (word_len_r == FIXED_LEN[i] && word_text_r == FIXED_TEXT[i]) begin
        word_kind = FIXED_KIND[i];
      end
    end
  end

  always_comb begin
    is_delim = (in_byte == CH_NUL) || (in_byte == CH_SP) || (in_byte == CH_TAB) ||
               (in_byte == CH_LF) || (in_byte == CH_OPEN) || (in_byte == CH_CLOSE) ||
               (in_byte == CH_COLON);
    is_letter = ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z)) ||
                ((in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_Z));
    col_bump = (col_r != POS_MAX) ? col_r + POS_ONE : col_r;
    own_kind = (in_byte == CH_OPEN) ? KIND_OPEN :
               (in_byte == CH_CLOSE) ? KIND_CLOSE : KIND_COLON;
  end

  always_comb begin
    word_text_nxt = word_text_r;
    word_len_nxt  = word_len_r;
    letters_nxt   = letters_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    push          = '0;

    push.t0.kind   = word_kind;
    push.t0.text   = word_text_r;
    push.t0.length = word_len_r;
    push.t0.trunc  = (word_len_r > LEN_W'(TEXT_BYTES));
    push.t0.line   = OUT_POS_W'(row_r);
    push.t0.col    = OUT_POS_W'(col_r);

    push.t1.kind   = own_kind;
    push.t1.text   = TEXT_W'(in_byte);
    push.t1.length = LEN_W'(1);
    push.t1.trunc  = 1'b0;
    push.t1.line   = OUT_POS_W'(row_r);
    push.t1.col    = OUT_POS_W'(col_bump);

    if (acc) begin
      if (!is_delim) begin
        if (word_len_r < LEN_W'(TEXT_BYTES)) begin
          word_text_nxt[8*word_len_r[LANE_BITS-1:0] +: 8] = in_byte;
        end
        if (word_len_r != '1) word_len_nxt = word_len_r + LEN_W'(1);
        if (!is_letter) letters_nxt = 1'b0;
        col_nxt = col_bump;
      end else begin
        push.v0 = (word_len_r != '0);
        word_text_nxt = '0;
        word_len_nxt  = '0;
        letters_nxt   = 1'b1;
        case (in_byte)
          CH_NUL: begin
            row_nxt = POS_ONE;
            col_nxt = POS_ONE;
          end
          CH_LF: begin
            if (row_r != POS_MAX) row_nxt = row_r + POS_ONE;
            col_nxt = POS_ONE;
          end
          CH_SP, CH_TAB: begin
            col_nxt = col_bump;
          end
          default: begin
            col_nxt = col_bump;
            push.v1 = 1'b1;
          end
        endcase
        push.t1.last = 1'b1;
        push.t0.last = !push.v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_text_r <= '0;
      word_len_r  <= '0;
      letters_r   <= 1'b1;
      row_r       <= POS_ONE;
      col_r       <= POS_ONE;
    end else begin
      word_text_r <= word_text_nxt;
      word_len_r  <= word_len_nxt;
      letters_r   <= letters_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule

FILE: sv/sctl_outq.sv
module sctl_outq
  import sctl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output tok_t  out_tok
);

  tok_t             ent_r   [QUEUE_DEPTH];
  tok_t             ent_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base;
  logic             pop;
  logic             na, nb;
  tok_t             ta;

  always_comb begin
    pop  = (cnt_r != '0) && out_ready;
    base = cnt_r - CNT_W'(pop);
    na   = push.v0 || push.v1;
    nb   = push.v0 && push.v1;
    ta   = push.v0 ? push.t0 : push.t1;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      ent_nxt[i] = pop ? ent_r[i+1] : ent_r[i];
    end
    ent_nxt[QUEUE_DEPTH-1] = ent_r[QUEUE_DEPTH-1];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (na && base == CNT_W'(i)) begin
        ent_nxt[i] = ta;
      end else if (nb && (base + CNT_W'(1)) == CNT_W'(i)) begin
        ent_nxt[i] = push.t1;
      end
    end
    cnt_nxt = base + CNT_W'(na) + CNT_W'(nb);
  end

  assign space_ok  = (cnt_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_tok   = ent_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

endmodule

FILE: sv/source_token_lexer_top.sv
// Source token lexer.
// Input stream: one source byte per item on in_tdata; byte 0 ends the text,
// flushes any open word and returns the row and column counters to 1.
// Output stream: one token per item. tuser carries the token kind, tdata the
// text, length, truncation flag, row and column; tlast marks the final token
// caused by one input byte (a delimiter byte can cause up to two tokens).
// Throughput: one input byte per cycle while in_tready is high. Tokens leave
// at one per cycle while out_tready is high, so a run of bytes that each
// cause two tokens is paced by the output side. A token is queued when the
// byte that ends it is accepted; a second token of that byte follows it.
// Results pass through a four-entry output queue; in_tready is high while at
// least two entries are free and depends on registered state only.
// When the receiver stalls, the queue fills and in_tready drops; nothing is
// lost and held tokens stay stable.
// Reset (rst_n low, synchronous) empties the queue, clears the word buffer and
// sets row and column to 1.
module source_token_lexer_top
  import sctl_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [63:0] token_text, [71:64] token_length,
                                   // [72] text_truncated, [88:73] line_number,
                                   // [104:89] column_after, [111:105] zero
  output logic [3:0]   out_tuser,  // [3:0] token_kind
  output logic         out_tlast   // last_of_run
);

  push_t push;
  tok_t  head;
  logic  space_ok;
  logic  acc;

  assign in_tready = space_ok;
  assign acc       = in_tvalid && space_ok;

  sctl_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_tdata),
    .push    (push)
  );

  sctl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  assign out_tdata = {7'b0, head.col, head.line, head.trunc, head.length, head.text};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
